// File: src/lcdws_pkg.sv
// shared types, codes and constant tables of the character lcd write sequencer
// used by the front, queue, back and top files; no dependencies of its own
package lcdws_pkg;

   // request function codes
   localparam logic [2:0] FUNC_INIT     = 3'd0;
   localparam logic [2:0] FUNC_COMMAND  = 3'd1;
   localparam logic [2:0] FUNC_DATA     = 3'd2;
   localparam logic [2:0] FUNC_POSITION = 3'd3;
   localparam logic [2:0] FUNC_NUMBER   = 3'd4;

   // register indexes of the csr port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUS_IS_8BIT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_PULSE_US  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_WAIT_US     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_UP_WAIT_US = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_GAP_US      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_GAP_US     = 3'd5;

   // register reset values
   localparam logic        RST_BUS_IS_8BIT      = 1'b0;
   localparam logic [15:0] RST_ENABLE_PULSE_US  = 16'd2;
   localparam logic [15:0] RST_BYTE_WAIT_US     = 16'd2000;
   localparam logic [15:0] RST_POWER_UP_WAIT_US = 16'd40000;
   localparam logic [15:0] RST_INIT_GAP_US      = 16'd40;
   localparam logic [15:0] RST_CLEAR_GAP_US     = 16'd2000;

   // lcd command bytes and character codes
   localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0E;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] ADDR_LINE0       = 8'h80;
   localparam logic [7:0] ADDR_LINE1       = 8'hC0;
   localparam logic [7:0] NIBBLE_MASK      = 8'h0F;
   localparam logic [7:0] CHAR_ZERO        = 8'h30;

   // init walks eight jobs, number walks ten decimal places from the top
   localparam logic [2:0] INIT_LAST_STEP = 3'd7;
   localparam logic [3:0] DIGIT_TOP      = 4'd9;
   localparam logic [1:0] TRIAL_LAST     = 2'd3;

   typedef enum logic [1:0] {
      JOB_BYTE,
      JOB_WAIT,
      JOB_GAP
   } job_op_type;

   typedef enum logic [1:0] {
      HOLD_POWER,
      HOLD_INIT,
      HOLD_CLEAR
   } hold_sel_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_SINGLE,
      FRONT_INIT,
      FRONT_NUMBER
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   // one queued unit of work for the back end
   typedef struct packed {
      job_op_type   op;
      logic [7:0]   value;
      logic         rs;
      hold_sel_type hold_sel;
      logic         last;
   } job_type;

   // register file contents seen by the back end
   typedef struct packed {
      logic        bus_is_8bit;
      logic [15:0] enable_pulse_us;
      logic [15:0] byte_wait_us;
      logic [15:0] power_up_wait_us;
      logic [15:0] init_gap_us;
      logic [15:0] clear_gap_us;
   } cfg_type;

   // job list of the power-up sequence
   function automatic job_type init_job(input logic [2:0] step);
      job_type j;
      j = '{op: JOB_BYTE, value: 8'h00, rs: 1'b0, hold_sel: HOLD_POWER, last: 1'b0};
      case (step)
         3'd0: begin
            j.op = JOB_WAIT;
         end
         3'd1: begin
            j.value = CMD_FUNCTION_SET;
         end
         3'd2: begin
            j.op = JOB_GAP;
            j.hold_sel = HOLD_INIT;
         end
         3'd3: begin
            j.value = CMD_DISPLAY_ON;
         end
         3'd4: begin
            j.op = JOB_GAP;
            j.hold_sel = HOLD_INIT;
         end
         3'd5: begin
            j.value = CMD_CLEAR;
         end
         3'd6: begin
            j.op = JOB_GAP;
            j.hold_sel = HOLD_CLEAR;
         end
         default: begin
            j.value = CMD_ENTRY_MODE;
            j.last = 1'b1;
         end
      endcase
      return j;
   endfunction

   // trial weight of a decimal place: 10^k scaled by 8, 4, 2 or 1
   function automatic logic [33:0] dec_weight(input logic [3:0] k, input logic [1:0] j);
      logic [33:0] p;
      case (k)
         4'd0:    p = 34'd1;
         4'd1:    p = 34'd10;
         4'd2:    p = 34'd100;
         4'd3:    p = 34'd1000;
         4'd4:    p = 34'd10000;
         4'd5:    p = 34'd100000;
         4'd6:    p = 34'd1000000;
         4'd7:    p = 34'd10000000;
         4'd8:    p = 34'd100000000;
         4'd9:    p = 34'd1000000000;
         default: p = 34'd0;
      endcase
      return p << (TRIAL_LAST - j);
   endfunction

endpackage

// File: src/lcdws_req_if.sv
// request channel of the lcd write sequencer: valid, ready and request fields
// no dependencies
interface lcdws_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [7:0]  byte_value;
   logic        line;
   logic [5:0]  column;
   logic [31:0] number;

   modport source (output valid, func, byte_value, line, column, number, input ready);
   modport sink   (input valid, func, byte_value, line, column, number, output ready);
endinterface

// File: src/lcdws_rsp_if.sv
// phase channel of the lcd write sequencer: valid, ready and pin phase fields
// no dependencies
interface lcdws_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_bus;
   logic        register_select;
   logic        enable;
   logic [15:0] hold_us;
   logic        last;

   modport source (output valid, data_bus, register_select, enable, hold_us, last, input ready);
   modport sink   (input valid, data_bus, register_select, enable, hold_us, last, output ready);
endinterface

// File: src/lcdws_front.sv
// front end: accepts requests and breaks them into byte, wait and gap jobs
// depends on lcdws_pkg and lcdws_req_if
module lcdws_front (
   input  logic                clock,
   input  logic                reset,
   lcdws_req_if.sink           req,
   output logic                push_valid,
   output lcdws_pkg::job_type  push_job,
   input  logic                push_ready
);

   lcdws_pkg::front_state_type state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic [3:0]         k_ff, k_in;
   logic [1:0]         sub_ff, sub_in;
   logic [31:0]        rem_ff, rem_in;
   logic [3:0]         digit_ff, digit_in;
   logic               started_ff, started_in;
   lcdws_pkg::job_type single_ff, single_in;

   logic [33:0]        trial_weight;
   logic               fits;
   logic [31:0]        rem_next;
   logic [3:0]         digit_total;
   logic               emit;
   lcdws_pkg::job_type digit_job;
   logic [7:0]         pos_addr;

   // one restoring trial subtraction per cycle, held while a digit waits on a full queue; weights 8, 4, 2, 1 of 10^k
   always_comb begin
      trial_weight = lcdws_pkg::dec_weight(k_ff, sub_ff);
      fits         = {2'b00, rem_ff} >= trial_weight;
      rem_next     = fits ? (rem_ff - trial_weight[31:0]) : rem_ff;
      digit_total  = digit_ff | (fits ? (4'b1000 >> sub_ff) : 4'b0000);
      emit         = (sub_ff == lcdws_pkg::TRIAL_LAST) &&
                     ((digit_total != 4'd0) || started_ff || (k_ff == 4'd0));
      digit_job    = '{op: lcdws_pkg::JOB_BYTE,
                       value: lcdws_pkg::CHAR_ZERO + {4'b0000, digit_total},
                       rs: 1'b1, hold_sel: lcdws_pkg::HOLD_POWER,
                       last: (k_ff == 4'd0)};
      pos_addr     = (req.line ? lcdws_pkg::ADDR_LINE1 : lcdws_pkg::ADDR_LINE0) +
                     {2'b00, req.column};
   end

   // request classification and job sequencing
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      k_in       = k_ff;
      sub_in     = sub_ff;
      rem_in     = rem_ff;
      digit_in   = digit_ff;
      started_in = started_ff;
      single_in  = single_ff;
      req.ready  = 1'b0;
      push_valid = 1'b0;
      push_job   = single_ff;
      case (state_ff)
         lcdws_pkg::FRONT_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               case (req.func)
                  lcdws_pkg::FUNC_INIT: begin
                     step_in  = 3'd0;
                     state_in = lcdws_pkg::FRONT_INIT;
                  end
                  lcdws_pkg::FUNC_COMMAND, lcdws_pkg::FUNC_DATA: begin
                     single_in = '{op: lcdws_pkg::JOB_BYTE, value: req.byte_value,
                                   rs: (req.func == lcdws_pkg::FUNC_DATA),
                                   hold_sel: lcdws_pkg::HOLD_POWER, last: 1'b1};
                     state_in  = lcdws_pkg::FRONT_SINGLE;
                  end
                  lcdws_pkg::FUNC_POSITION: begin
                     single_in = '{op: lcdws_pkg::JOB_BYTE, value: pos_addr, rs: 1'b0,
                                   hold_sel: lcdws_pkg::HOLD_POWER, last: 1'b1};
                     state_in  = lcdws_pkg::FRONT_SINGLE;
                  end
                  lcdws_pkg::FUNC_NUMBER: begin
                     rem_in     = req.number;
                     k_in       = lcdws_pkg::DIGIT_TOP;
                     sub_in     = 2'd0;
                     digit_in   = 4'd0;
                     started_in = 1'b0;
                     state_in   = lcdws_pkg::FRONT_NUMBER;
                  end
                  default: begin
                     // unknown function codes are dropped
                     state_in = lcdws_pkg::FRONT_IDLE;
                  end
               endcase
            end
         end
         lcdws_pkg::FRONT_SINGLE: begin
            push_valid = 1'b1;
            push_job   = single_ff;
            if (push_ready) begin
               state_in = lcdws_pkg::FRONT_IDLE;
            end
         end
         lcdws_pkg::FRONT_INIT: begin
            push_valid = 1'b1;
            push_job   = lcdws_pkg::init_job(step_ff);
            if (push_ready) begin
               if (step_ff == lcdws_pkg::INIT_LAST_STEP) begin
                  state_in = lcdws_pkg::FRONT_IDLE;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
         end
         lcdws_pkg::FRONT_NUMBER: begin
            push_job = digit_job;
            if (sub_ff != lcdws_pkg::TRIAL_LAST) begin
               rem_in   = rem_next;
               digit_in = digit_total;
               sub_in   = sub_ff + 2'd1;
            end else begin
               // leading zeros are skipped, the units place always goes out
               push_valid = emit;
               if (!emit || push_ready) begin
                  rem_in     = rem_next;
                  digit_in   = 4'd0;
                  sub_in     = 2'd0;
                  started_in = started_ff | emit;
                  if (k_ff == 4'd0) begin
                     state_in = lcdws_pkg::FRONT_IDLE;
                  end else begin
                     k_in = k_ff - 4'd1;
                  end
               end
            end
         end
         default: begin
            state_in = lcdws_pkg::FRONT_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcdws_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      k_ff       <= k_in;
      sub_ff     <= sub_in;
      rem_ff     <= rem_in;
      digit_ff   <= digit_in;
      started_ff <= started_in;
      single_ff  <= single_in;
   end

   // a finished decimal digit never exceeds nine
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcdws_pkg::FRONT_NUMBER) && (sub_ff == lcdws_pkg::TRIAL_LAST)
      |-> (digit_total <= 4'd9))
      else $error("decimal digit out of range");

endmodule

// File: src/lcdws_queue.sv
// short job queue between front and back ends, held in flip-flops
// depends on lcdws_pkg
module lcdws_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  lcdws_pkg::job_type push_job,
   output logic               push_ready,
   output logic               pop_valid,
   output lcdws_pkg::job_type pop_job,
   input  logic               pop_ready
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lcdws_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   // pointer and fill count update
   always_comb begin
      push_ready = (count_ff != CNT_FULL);
      pop_valid  = (count_ff != '0);
      pop_job    = entries_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("queue fill count past depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty with pointers apart");

endmodule

// File: src/lcdws_back.sv
// back end: turns queued jobs into timed pin phases behind an output register
// depends on lcdws_pkg and lcdws_rsp_if
module lcdws_back (
   input  logic               clock,
   input  logic               reset,
   input  lcdws_pkg::cfg_type cfg,
   input  logic               pop_valid,
   input  lcdws_pkg::job_type pop_job,
   output logic               pop_ready,
   lcdws_rsp_if.source        rsp
);

   lcdws_pkg::back_state_type state_ff, state_in;
   lcdws_pkg::job_type job_ff, job_in;
   logic [1:0]         phase_ff, phase_in;
   logic [7:0]         last_bus_ff, last_bus_in;
   logic               last_rs_ff, last_rs_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_bus_ff, out_bus_in;
   logic               out_rs_ff, out_rs_in;
   logic               out_en_ff, out_en_in;
   logic [15:0]        out_hold_ff, out_hold_in;
   logic               out_last_ff, out_last_in;

   logic [7:0]         ph_bus;
   logic               ph_rs;
   logic               ph_en;
   logic [15:0]        ph_hold;
   logic               ph_final;
   logic [15:0]        sel_hold;
   logic               slot_free;

   // pin phase of the current job
   always_comb begin
      case (job_ff.hold_sel)
         lcdws_pkg::HOLD_INIT:  sel_hold = cfg.init_gap_us;
         lcdws_pkg::HOLD_CLEAR: sel_hold = cfg.clear_gap_us;
         default:               sel_hold = cfg.power_up_wait_us;
      endcase
      ph_bus   = 8'h00;
      ph_rs    = 1'b0;
      ph_en    = 1'b0;
      ph_hold  = sel_hold;
      ph_final = 1'b1;
      case (job_ff.op)
         lcdws_pkg::JOB_BYTE: begin
            ph_rs = job_ff.rs;
            if (cfg.bus_is_8bit) begin
               ph_bus   = job_ff.value;
               ph_en    = (phase_ff == 2'd0);
               ph_hold  = ph_en ? cfg.enable_pulse_us : cfg.byte_wait_us;
               ph_final = (phase_ff == 2'd1);
            end else begin
               // high nibble pulse, then low nibble pulse
               ph_bus   = phase_ff[1] ? (job_ff.value & lcdws_pkg::NIBBLE_MASK)
                                      : {4'b0000, job_ff.value[7:4]};
               ph_en    = !phase_ff[0];
               ph_hold  = phase_ff[0] ? (phase_ff[1] ? cfg.byte_wait_us : 16'd0)
                                      : cfg.enable_pulse_us;
               ph_final = (phase_ff == 2'd3);
            end
         end
         lcdws_pkg::JOB_WAIT: begin
            ph_bus = 8'h00;
            ph_rs  = 1'b0;
         end
         lcdws_pkg::JOB_GAP: begin
            // gap repeats the bus and rs of the phase before it
            ph_bus = last_bus_ff;
            ph_rs  = last_rs_ff;
         end
         default: begin
            ph_final = 1'b1;
         end
      endcase
   end

   // job fetch and phase stepping
   always_comb begin
      slot_free    = !out_valid_ff || rsp.ready;
      state_in     = state_ff;
      job_in       = job_ff;
      phase_in     = phase_ff;
      last_bus_in  = last_bus_ff;
      last_rs_in   = last_rs_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_bus_in   = out_bus_ff;
      out_rs_in    = out_rs_ff;
      out_en_in    = out_en_ff;
      out_hold_in  = out_hold_ff;
      out_last_in  = out_last_ff;
      pop_ready    = 1'b0;
      case (state_ff)
         lcdws_pkg::BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               job_in   = pop_job;
               phase_in = 2'd0;
               state_in = lcdws_pkg::BACK_RUN;
            end
         end
         lcdws_pkg::BACK_RUN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_bus_in   = ph_bus;
               out_rs_in    = ph_rs;
               out_en_in    = ph_en;
               out_hold_in  = ph_hold;
               out_last_in  = ph_final && job_ff.last;
               last_bus_in  = ph_bus;
               last_rs_in   = ph_rs;
               if (ph_final) begin
                  state_in = lcdws_pkg::BACK_IDLE;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = lcdws_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcdws_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // job and output payload registers
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      phase_ff    <= phase_in;
      last_bus_ff <= last_bus_in;
      last_rs_ff  <= last_rs_in;
      out_bus_ff  <= out_bus_in;
      out_rs_ff   <= out_rs_in;
      out_en_ff   <= out_en_in;
      out_hold_ff <= out_hold_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.data_bus        = out_bus_ff;
   assign rsp.register_select = out_rs_ff;
   assign rsp.enable          = out_en_ff;
   assign rsp.hold_us         = out_hold_ff;
   assign rsp.last            = out_last_ff;

   // a newly valid phase is only loaded while the back end runs a job
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == lcdws_pkg::BACK_RUN))
      else $error("phase loaded without an active job");

endmodule

// File: src/char_lcd_write_sequencer_core.sv
// top level of the character lcd write sequencer: csr registers, front, queue, back
// depends on lcdws_pkg, lcdws_req_if, lcdws_rsp_if and the lcdws_* modules
//
//   channel  direction  transfer rule             carries
//   req_if   in         valid & ready at clock    func, byte_value, line, column, number
//   rsp_if   out        valid & ready at clock    data_bus, register_select, enable,
//                                                 hold_us, last
//   csr_*    in         csr_write_enable at clock csr_index, csr_write_data
//
// back end: fetches a job, then puts out one phase a cycle while rsp_if is ready;
// a byte is 2 phases on the 8-bit bus or 4 on the 4-bit bus, init 12 or 20 phases
// front end: takes a request, then breaks it into jobs; a number takes four trial
// subtractions per place; a request is taken only while the front end is idle; a full
// queue stalls the front end, a stalled rsp_if stalls the back end; reset clears
// control state and loads the csr registers with their reset values
module char_lcd_write_sequencer_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   lcdws_req_if.sink                         req_if,
   lcdws_rsp_if.source                       rsp_if,
   input  logic                              csr_write_enable,
   input  logic [lcdws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lcdws_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   lcdws_pkg::cfg_type cfg_ff, cfg_in;
   logic               push_valid, push_ready;
   lcdws_pkg::job_type push_job;
   logic               pop_valid, pop_ready;
   lcdws_pkg::job_type pop_job;

   // register writes, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lcdws_pkg::CSR_BUS_IS_8BIT:      cfg_in.bus_is_8bit      = csr_write_data[0];
            lcdws_pkg::CSR_ENABLE_PULSE_US:  cfg_in.enable_pulse_us  = csr_write_data;
            lcdws_pkg::CSR_BYTE_WAIT_US:     cfg_in.byte_wait_us     = csr_write_data;
            lcdws_pkg::CSR_POWER_UP_WAIT_US: cfg_in.power_up_wait_us = csr_write_data;
            lcdws_pkg::CSR_INIT_GAP_US:      cfg_in.init_gap_us      = csr_write_data;
            lcdws_pkg::CSR_CLEAR_GAP_US:     cfg_in.clear_gap_us     = csr_write_data;
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bus_is_8bit      <= lcdws_pkg::RST_BUS_IS_8BIT;
         cfg_ff.enable_pulse_us  <= lcdws_pkg::RST_ENABLE_PULSE_US;
         cfg_ff.byte_wait_us     <= lcdws_pkg::RST_BYTE_WAIT_US;
         cfg_ff.power_up_wait_us <= lcdws_pkg::RST_POWER_UP_WAIT_US;
         cfg_ff.init_gap_us      <= lcdws_pkg::RST_INIT_GAP_US;
         cfg_ff.clear_gap_us     <= lcdws_pkg::RST_CLEAR_GAP_US;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request classification
   lcdws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   // job queue
   lcdws_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   // phase generation
   lcdws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .rsp       (rsp_if)
   );

endmodule
